### hdl/uidal_pkg.sv
package uidal_pkg;

  // operating modes
  localparam logic [1:0] MODE_CHECK  = 2'd0;
  localparam logic [1:0] MODE_ENROLL = 2'd1;
  localparam logic [1:0] MODE_REVOKE = 2'd2;

  // result status codes
  localparam logic [2:0] ST_GRANTED   = 3'd0;
  localparam logic [2:0] ST_DENIED    = 3'd1;
  localparam logic [2:0] ST_ADDED     = 3'd2;
  localparam logic [2:0] ST_PRESENT   = 3'd3;
  localparam logic [2:0] ST_DELETED   = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SEARCH,
    FSM_DECIDE,
    FSM_SHIFT
  } fsm_state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;        // capture card id, restart scan
    logic       scan_step;   // issue next read, compare previous
    logic       shift_init;  // point scan just past the match
    logic       shift_step;  // move one entry down
    logic       add_write;   // append card, bump count
    logic       del_dec;     // drop count by one
    logic       finish;      // register the result
    logic [2:0] code;
    logic       granted;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       match;       // read data equals the card id
    logic       scan_done;   // nothing in flight, nothing left to read
    logic       hit;         // card found during search
    logic       full;        // count reached capacity
  } dp_stat_t;

endpackage

### hdl/uidal_ctrl.sv
module uidal_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  uidal_pkg::dp_stat_t    stat,
  output uidal_pkg::ctrl_cmd_t   cmd
);

  uidal_pkg::fsm_state_t state;
  uidal_pkg::fsm_state_t state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uidal_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      uidal_pkg::FSM_IDLE: begin
        if (start) state_next = uidal_pkg::FSM_SEARCH;
      end
      uidal_pkg::FSM_SEARCH: begin
        if (stat.match || stat.scan_done) state_next = uidal_pkg::FSM_DECIDE;
      end
      uidal_pkg::FSM_DECIDE: begin
        if (stat.mode == uidal_pkg::MODE_REVOKE && stat.hit) begin
          state_next = uidal_pkg::FSM_SHIFT;
        end else begin
          state_next = uidal_pkg::FSM_IDLE;
        end
      end
      uidal_pkg::FSM_SHIFT: begin
        if (stat.scan_done) state_next = uidal_pkg::FSM_IDLE;
      end
      default: state_next = uidal_pkg::FSM_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = (state != uidal_pkg::FSM_IDLE);
    case (state)
      uidal_pkg::FSM_IDLE: begin
        cmd.load = start;
      end
      uidal_pkg::FSM_SEARCH: begin
        cmd.scan_step = 1'b1;
      end
      uidal_pkg::FSM_DECIDE: begin
        case (stat.mode)
          uidal_pkg::MODE_ENROLL: begin
            cmd.finish = 1'b1;
            if (stat.hit) begin
              cmd.code = uidal_pkg::ST_PRESENT;
            end else if (stat.full) begin
              cmd.code = uidal_pkg::ST_FULL;
            end else begin
              cmd.code      = uidal_pkg::ST_ADDED;
              cmd.add_write = 1'b1;
            end
          end
          uidal_pkg::MODE_REVOKE: begin
            if (stat.hit) begin
              cmd.shift_init = 1'b1;
            end else begin
              cmd.finish = 1'b1;
              cmd.code   = uidal_pkg::ST_NOT_FOUND;
            end
          end
          default: begin
            cmd.finish  = 1'b1;
            cmd.granted = stat.hit;
            cmd.code    = stat.hit ? uidal_pkg::ST_GRANTED : uidal_pkg::ST_DENIED;
          end
        endcase
      end
      uidal_pkg::FSM_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.scan_done) begin
          cmd.del_dec = 1'b1;
          cmd.finish  = 1'b1;
          cmd.code    = uidal_pkg::ST_DELETED;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hdl/uidal_dp.sv
module uidal_dp #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            card_id,
  input  logic                   cfg_valid,
  input  logic [1:0]             cfg_data,
  input  uidal_pkg::ctrl_cmd_t   cmd,
  output uidal_pkg::dp_stat_t    stat,
  output logic                   result_valid,
  output logic [2:0]             status_code,
  output logic                   access_granted,
  output logic [3:0]             match_position,
  output logic                   match_found,
  output logic [4:0]             entries_in_use
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [31:0]   mem [MAX_ENTRIES];
  logic [31:0]   rdata;
  logic [31:0]   id_reg;
  logic [1:0]    mode;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic [CW-1:0] idx;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] pos;
  logic          pend;
  logic          hit;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          more;
  logic [AW+3:0] pos_ext;
  logic [CW+4:0] cnt_ext;

  // status to controller
  assign more           = (idx < cnt);
  assign stat.mode      = mode;
  assign stat.match     = pend && (rdata == id_reg);
  assign stat.scan_done = !pend && !more;
  assign stat.hit       = hit;
  assign stat.full      = (cnt == CW'(MAX_ENTRIES));

  // memory port control
  assign rd_en = (cmd.scan_step || cmd.shift_step) && more;
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt[AW-1:0];
    wr_data = id_reg;
    if (cmd.add_write) begin
      wr_en = 1'b1;
    end else if (cmd.shift_step && pend) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx - AW'(1);
      wr_data = rdata;
    end
  end

  // card store
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[idx[AW-1:0]];
  end

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= uidal_pkg::MODE_CHECK;
    end else if (cfg_valid) begin
      mode <= cfg_data;
    end
  end

  // entry count
  always_comb begin
    cnt_next = cnt;
    if (cmd.add_write) cnt_next = cnt + CW'(1);
    else if (cmd.del_dec) cnt_next = cnt - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // scan pointer and match capture
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      hit  <= 1'b0;
    end else if (cmd.load) begin
      id_reg <= card_id;
      idx    <= '0;
      pend   <= 1'b0;
      hit    <= 1'b0;
    end else if (cmd.shift_init) begin
      idx  <= CW'(pos) + CW'(1);
      pend <= 1'b0;
    end else if (cmd.scan_step || cmd.shift_step) begin
      pend <= more;
      if (more) begin
        idx    <= idx + CW'(1);
        rd_idx <= idx[AW-1:0];
      end
      if (cmd.scan_step && stat.match) begin
        hit <= 1'b1;
        pos <= rd_idx;
      end
    end
  end

  // result registers
  assign pos_ext = {4'b0, pos};
  assign cnt_ext = {5'b0, cnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status_code    <= cmd.code;
      access_granted <= cmd.granted;
      match_found    <= hit;
      match_position <= hit ? pos_ext[3:0] : 4'd0;
      entries_in_use <= cnt_ext[4:0];
    end
  end

endmodule

### hdl/uid_allow_list_table.sv
// Card identifier allow list.
//
// Request channel: drive card_id and raise start; the request is taken at a
// clock edge where start is high and busy is low. busy stays high until the
// result has been registered, so one request is in work at a time.
// Config channel: cfg_valid with cfg_data (0 check, 1 add, 2 delete, 3 acts
// as check) writes the mode; cfg_ready is always high. Change the mode only
// while busy is low.
// Result: result_valid pulses for one cycle with status_code, access_granted,
// match_position, match_found and entries_in_use. The receiver cannot stall
// it; a result not taken in that cycle is gone.
// Search: the store is read one entry per cycle through its registered
// read port and the search stops at the first match, so check and add
// strobe the result once the search ends at a match or at the end of the
// list. A delete then moves each later entry down one per cycle through
// the same port before its result strobes. busy drops in the cycle the
// result strobes, so a new request may follow at once.
// Reset clears the count and the mode; the store itself is not cleared,
// since only entries below the count are ever read.
module uid_allow_list_table #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] card_id,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  output logic        result_valid,
  output logic [2:0]  status_code,
  output logic        access_granted,
  output logic [3:0]  match_position,
  output logic        match_found,
  output logic [4:0]  entries_in_use
);

  uidal_pkg::ctrl_cmd_t cmd;
  uidal_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  uidal_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  uidal_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .card_id        (card_id),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat),
    .result_valid   (result_valid),
    .status_code    (status_code),
    .access_granted (access_granted),
    .match_position (match_position),
    .match_found    (match_found),
    .entries_in_use (entries_in_use)
  );

endmodule
